/* rtl/core/udiv_pkg.sv */
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared types and constants for the unsigned restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned NARROW_BITS = 32;
  localparam int unsigned WIDE_BITS   = 64;
  localparam int unsigned CNT_W       = $clog2(WIDE_BITS + 1);

  // operand width select
  localparam logic OP_NARROW = 1'b0;
  localparam logic OP_WIDE   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steps_done;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/unsigned_restoring_divider.sv */
// ----------------------------------------------------------------------------
// unsigned_restoring_divider
// Radix-2 restoring unsigned divider, 32-bit or 64-bit operands.
// ----------------------------------------------------------------------------
// One item at a time. An accepted item spends one cycle per quotient bit in a
// single shared 65-bit subtract-and-compare unit (32 steps for a 32-bit divide,
// 64 for a 64-bit divide); the result then moves into the output register once
// that register is free, and the next item can be taken after that move. A zero
// divisor skips the steps. The output register lets the next item start while a
// finished result waits to be taken.
`default_nettype none

module unsigned_restoring_divider (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire udiv_pkg::in_item_t    in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output udiv_pkg::out_item_t        out_item
);
  import udiv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  udiv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  udiv_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

/* rtl/core/udiv_dp.sv */
// ----------------------------------------------------------------------------
// udiv_dp
// Divider datapath: operand registers, partial remainder, quotient shift
// register, step counter, one shared 65-bit subtractor and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire udiv_pkg::in_item_t    in_item,
  input  wire udiv_pkg::dp_cmd_t     cmd,
  output udiv_pkg::dp_status_t       status,
  output udiv_pkg::out_item_t        out_item
);
  import udiv_pkg::*;

  logic [DATA_W-1:0] num;
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              dz;
  out_item_t         res;

  logic [DATA_W-1:0] num_in;
  logic [DATA_W-1:0] den_in;
  logic              dz_in;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              qbit;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    if (in_item.op == OP_WIDE) begin
      num_in = in_item.dividend;
      den_in = in_item.divisor;
    end else begin
      // narrow dividend sits in the top half so the msb shifts out first
      num_in = {in_item.dividend[NARROW_BITS-1:0], {(DATA_W-NARROW_BITS){1'b0}}};
      den_in = {{(DATA_W-NARROW_BITS){1'b0}}, in_item.divisor[NARROW_BITS-1:0]};
    end
    dz_in = (den_in == '0);
  end

  // partial remainder stays below den, so a set bit 64 of diff means borrow
  always_comb begin
    shifted  = {rem, num[DATA_W-1]};
    diff     = shifted - {1'b0, den};
    qbit     = ~diff[DATA_W];
    rem_next = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      if (dz_in) begin
        cnt <= '0;
      end else if (in_item.op == OP_WIDE) begin
        cnt <= CNT_W'(WIDE_BITS);
      end else begin
        cnt <= CNT_W'(NARROW_BITS);
      end
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= num_in;
      den <= den_in;
      rem <= '0;
      quo <= '0;
      dz  <= dz_in;
    end else if (cmd.step) begin
      num <= {num[DATA_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[DATA_W-2:0], qbit};
    end
    if (cmd.publish) begin
      res.quotient       <= quo;
      res.remainder      <= rem;
      res.divide_by_zero <= dz;
    end
  end

  assign status.steps_done = (cnt == '0);
  assign out_item          = res;

endmodule

`default_nettype wire

/* rtl/core/udiv_ctrl.sv */
// ----------------------------------------------------------------------------
// udiv_ctrl
// Divider controller: handshakes, step sequencing and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output udiv_pkg::dp_cmd_t          cmd,
  input  wire udiv_pkg::dp_status_t  status
);
  import udiv_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = ~out_valid | out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step    = ~status.steps_done;
        cmd.publish = status.steps_done & slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd.publish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/udiv_checker.sv */
// ----------------------------------------------------------------------------
// udiv_checker
// Port-level checks for the unsigned restoring divider, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire udiv_pkg::out_item_t  out_item
);
  import udiv_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // returning to idle always comes with a fresh result
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(in_ready) |-> out_valid)
    else $error("divider went idle without a result");

  // zero divisor forces zero outputs
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.divide_by_zero |->
      out_item.quotient == '0 && out_item.remainder == '0)
    else $error("divide by zero with nonzero result");

endmodule

bind unsigned_restoring_divider udiv_checker u_udiv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
